/* hw/rtl/gka_pkg.sv */
// Shared types and constants for the gamepad key autorepeat block.
`default_nettype none

package gka_pkg;

    localparam int NUM_BUTTONS_DEF = 14;
    localparam int COUNT_WIDTH_DEF = 5;
    localparam int MAX_SLOTS       = 16;
    localparam int SLOT_W          = 4;

    localparam int BTN_W      = 14;
    localparam int KEY_W      = 4;
    localparam int EV_W       = 3;
    localparam int USER_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_DATA_W-1:0] REPEAT_PERIOD_RST = CFG_DATA_W'(5);
    localparam logic [CFG_DATA_W-1:0] INITIAL_DELAY_RST = CFG_DATA_W'(5 * 4);
    localparam logic [USER_W-1:0]     USER_INDEX_RST    = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_INDEX    = 2'd2;

    localparam logic [EV_W-1:0] EV_NONE    = 3'b000;
    localparam logic [EV_W-1:0] EV_KEYDOWN = 3'b001;
    localparam logic [EV_W-1:0] EV_KEYUP   = 3'b010;
    localparam logic [EV_W-1:0] EV_REPEAT  = 3'b100;

    typedef enum logic [1:0] {
        KS_IDLE     = 2'd0,
        KS_DOWN     = 2'd1,
        KS_DOWN_RPT = 2'd2,
        KS_UP       = 2'd3
    } t_key_state;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SCAN,
        SQ_DONE
    } t_seq_state;

    typedef struct packed {
        logic            stop;
        logic            has_key;
        logic [EV_W-1:0] ev;
    } t_step_res;

endpackage

`default_nettype wire

/* hw/rtl/gamepad_keystroke_autorepeat.sv */
// Top level: poll sequencer, config registers and result register.
//
//  channel | dir  | handshake                   | payload
//  in      | sink | i_in_valid / o_in_stall     | i_buttons
//  out     | src  | o_out_valid / i_out_stall   | o_has_key, o_key_index,
//          |      |                             | o_event_flags, o_user_out
//  cfg     | sink | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Each item is accepted in idle; the shared step unit then checks one table entry
// per cycle until a button ends the scan or the last entry is done, the done state
// hands the result to the output register when that register is free or unstalled,
// and the sequencer goes back to idle. No new item is taken before that hand-off.
// Synchronous active-low reset clears all key states and countdowns at once.
// The output register frees the input side while a result waits under stall.
`default_nettype none

module gamepad_keystroke_autorepeat #(
    parameter int NUM_BUTTONS = gka_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = gka_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [gka_pkg::BTN_W-1:0]       i_buttons,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_has_key,
    output logic [gka_pkg::KEY_W-1:0]       o_key_index,
    output logic [gka_pkg::EV_W-1:0]        o_event_flags,
    output logic [gka_pkg::USER_W-1:0]      o_user_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gka_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gka_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gka_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    t_seq_state              r_seq;
    t_seq_state              n_seq;
    logic [IDX_W-1:0]        r_idx;
    logic [BTN_W-1:0]        r_buttons;
    logic [CFG_DATA_W-1:0]   r_repeat_period;
    logic [CFG_DATA_W-1:0]   r_initial_delay;
    logic [USER_W-1:0]       r_user_index;
    logic                    r_res_has;
    logic [KEY_W-1:0]        r_res_key;
    logic [EV_W-1:0]         r_res_ev;
    logic                    r_out_valid;
    logic                    r_out_has;
    logic [KEY_W-1:0]        r_out_key;
    logic [EV_W-1:0]         r_out_ev;
    logic [USER_W-1:0]       r_out_user;

    logic [MAX_SLOTS-1:0]    w_btn_ext;
    logic                    w_pressed;
    logic                    w_last;
    logic                    w_accept;
    logic                    w_step;
    logic                    w_finish;
    logic                    w_load_out;
    t_step_res               w_res;

    assign w_btn_ext = {(MAX_SLOTS - BTN_W)'(0), r_buttons};
    assign w_pressed = w_btn_ext[SLOT_W'(r_idx)];
    assign w_last    = (r_idx == IDX_W'(NUM_BUTTONS - 1));
    assign w_accept  = i_in_valid && !o_in_stall;

    gka_key_step #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W)
    ) u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_idx           (r_idx),
        .i_pressed       (w_pressed),
        .i_repeat_period (r_repeat_period),
        .i_initial_delay (r_initial_delay),
        .o_res           (w_res)
    );

    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE: if (w_accept) n_seq = SQ_SCAN;
            SQ_SCAN: if (w_finish) n_seq = SQ_DONE;
            SQ_DONE: if (w_load_out) n_seq = SQ_IDLE;
            default: n_seq = SQ_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_seq != SQ_IDLE);
        w_step     = (r_seq == SQ_SCAN);
        w_finish   = w_step && (w_res.stop || w_last);
        w_load_out = (r_seq == SQ_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq           <= SQ_IDLE;
            r_idx           <= '0;
            r_out_valid     <= 1'b0;
            r_repeat_period <= REPEAT_PERIOD_RST;
            r_initial_delay <= INITIAL_DELAY_RST;
            r_user_index    <= USER_INDEX_RST;
        end else begin
            r_seq <= n_seq;
            if (w_accept) begin
                r_idx <= '0;
            end else if (w_step && !w_finish) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data;
                    CFG_INITIAL_DELAY: r_initial_delay <= i_cfg_data;
                    CFG_USER_INDEX:    r_user_index    <= i_cfg_data[USER_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buttons <= i_buttons;
        end
        if (w_finish) begin
            r_res_has <= w_res.has_key;
            r_res_key <= w_res.has_key ? KEY_W'(r_idx) : '0;
            r_res_ev  <= w_res.ev;
        end
        if (w_load_out) begin
            r_out_has  <= r_res_has;
            r_out_key  <= r_res_key;
            r_out_ev   <= r_res_ev;
            r_out_user <= r_user_index;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_has_key     = r_out_has;
    assign o_key_index   = r_out_key;
    assign o_event_flags = r_out_ev;
    assign o_user_out    = r_out_user;

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_seq == SQ_SCAN) && (r_idx == '0))
        else $error("scan did not start at the first button");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_key) |-> (o_key_index == '0) && (o_event_flags == EV_NONE))
        else $error("empty result carries a key or flags");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_has_key) |->
            (o_event_flags == EV_KEYDOWN) || (o_event_flags == EV_KEYUP) ||
            (o_event_flags == (EV_KEYDOWN | EV_REPEAT)))
        else $error("bad event flags on a key result");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |-> (r_idx <= IDX_W'(NUM_BUTTONS - 1)))
        else $error("scan index past last button");

endmodule

`default_nettype wire

/* hw/rtl/gka_key_step.sv */
// Per-button state table; decides one button in each i_step cycle.
`default_nettype none

module gka_key_step #(
    parameter int NUM_BUTTONS = gka_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = gka_pkg::COUNT_WIDTH_DEF,
    parameter int IDX_W       = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [IDX_W-1:0]                i_idx,
    input  logic                            i_pressed,
    input  logic [gka_pkg::CFG_DATA_W-1:0]  i_repeat_period,
    input  logic [gka_pkg::CFG_DATA_W-1:0]  i_initial_delay,
    output gka_pkg::t_step_res              o_res
);
    import gka_pkg::*;

    t_key_state             r_state [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] r_count [NUM_BUTTONS];

    t_key_state             w_st;
    logic [COUNT_WIDTH-1:0] w_cnt;
    t_key_state             n_st;
    logic [COUNT_WIDTH-1:0] n_cnt;

    assign w_st  = r_state[i_idx];
    assign w_cnt = r_count[i_idx];

    always_comb begin
        o_res = '0;
        n_st  = w_st;
        n_cnt = w_cnt;
        if (i_pressed) begin
            unique case (w_st)
                KS_IDLE: begin
                    n_st  = KS_DOWN;
                    o_res = '{stop: 1'b1, has_key: 1'b1, ev: EV_KEYDOWN};
                end
                KS_DOWN, KS_DOWN_RPT: begin
                    if (w_cnt == '0) begin
                        n_cnt = COUNT_WIDTH'(i_repeat_period);
                        n_st  = KS_DOWN_RPT;
                        o_res = '{stop: 1'b1, has_key: 1'b1, ev: EV_KEYDOWN | EV_REPEAT};
                    end else begin
                        n_cnt = w_cnt - COUNT_WIDTH'(1);
                    end
                end
                KS_UP: begin
                    n_st = KS_UP;
                end
                default: begin
                    n_st = w_st;
                end
            endcase
        end else begin
            unique case (w_st)
                KS_IDLE: begin
                    n_st = KS_IDLE;
                end
                KS_DOWN, KS_DOWN_RPT: begin
                    n_cnt = COUNT_WIDTH'(i_initial_delay);
                    n_st  = KS_UP;
                    o_res = '{stop: 1'b1, has_key: 1'b1, ev: EV_KEYUP};
                end
                KS_UP: begin
                    n_st  = KS_IDLE;
                    o_res = '{stop: 1'b1, has_key: 1'b0, ev: EV_NONE};
                end
                default: begin
                    n_st = w_st;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_state[i] <= KS_IDLE;
                r_count[i] <= '0;
            end
        end else if (i_step) begin
            r_state[i_idx] <= n_st;
            r_count[i_idx] <= n_cnt;
        end
    end

endmodule

`default_nettype wire
